// ===== design/config_descriptor_endpoint_finder_macros.svh =====
// Assertion macros shared by the endpoint finder modules.
`ifndef CONFIG_DESCRIPTOR_ENDPOINT_FINDER_MACROS_SVH
`define CONFIG_DESCRIPTOR_ENDPOINT_FINDER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CDEF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CDEF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cdef_pkg.sv =====
// Package: types, constants and helpers for the descriptor endpoint finder.
package cdef_pkg;

   // Descriptor layout
   localparam logic [7:0] LEN_MIN       = 8'd2;
   localparam logic [7:0] TYPE_IFACE    = 8'd4;
   localparam logic [7:0] TYPE_ENDPOINT = 8'd5;
   localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
   localparam logic [7:0] EP_MIN_LEN    = 8'd7;
   localparam logic [7:0] CLASS_HID     = 8'h03;
   localparam int         EP_DIR_BIT    = 7;
   localparam logic [1:0] XFER_INTR     = 2'b11;

   // Max packet handling
   localparam logic [7:0] MPS_LIMIT     = 8'd16;
   localparam logic [4:0] MPS_DEFAULT   = 5'd8;

   // Offsets of captured bytes
   localparam logic [7:0] OFF_LEN   = 8'd0;
   localparam logic [7:0] OFF_TYPE  = 8'd1;
   localparam logic [7:0] OFF_TWO   = 8'd2;
   localparam logic [7:0] OFF_THREE = 8'd3;
   localparam logic [7:0] OFF_FOUR  = 8'd4;
   localparam logic [7:0] OFF_FIVE  = 8'd5;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One classified event passed from the parser to the result side
   typedef struct packed {
      logic       last;
      logic       hid_iface;
      logic       int_in_ep;
      logic [7:0] byte_two;
      logic [7:0] byte_four;
   } cdef_event_type;

   // Max packet with fallback to the default when zero or too large
   function automatic logic [4:0] packet_fallback(input logic [7:0] mps);
      logic [4:0] res;
      if (mps == 8'd0 || mps > MPS_LIMIT) begin
         res = MPS_DEFAULT;
      end else begin
         res = mps[4:0];
      end
      return res;
   endfunction

endpackage

// ===== design/cdef_front.sv =====
// Front end: walks descriptor bytes and classifies completed descriptors.
module cdef_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    queue_full,
   output logic                    push,
   output cdef_pkg::cdef_event_type push_event
);
   import cdef_pkg::*;

   logic [7:0] off_ff, off_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] b2_ff, b2_in;
   logic [7:0] b3_ff, b3_in;
   logic [7:0] b4_ff, b4_in;
   logic [7:0] b5_ff, b5_in;
   logic       halted_ff, halted_in;

   logic       accept;
   logic       finish;
   logic       hid_iface;
   logic       int_in_ep;
   logic [8:0] off_next;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign off_next  = {1'b0, off_ff} + 9'd1;

   // Captured bytes as seen with the current byte merged in
   always_comb begin
      type_in = (off_ff == OFF_TYPE)  ? req_data_byte : type_ff;
      b2_in   = (off_ff == OFF_TWO)   ? req_data_byte : b2_ff;
      b3_in   = (off_ff == OFF_THREE) ? req_data_byte : b3_ff;
      b4_in   = (off_ff == OFF_FOUR)  ? req_data_byte : b4_ff;
      b5_in   = (off_ff == OFF_FIVE)  ? req_data_byte : b5_ff;
   end

   // Descriptor end and classification
   always_comb begin
      finish    = !halted_ff && (off_ff != OFF_LEN) && (off_next >= {1'b0, len_ff});
      hid_iface = finish && (type_in == TYPE_IFACE) && (len_ff >= IFACE_MIN_LEN)
                  && (b5_in == CLASS_HID);
      int_in_ep = finish && (type_in == TYPE_ENDPOINT) && (len_ff >= EP_MIN_LEN)
                  && b2_in[EP_DIR_BIT] && (b3_in[1:0] == XFER_INTR);
   end

   // Parser state update
   always_comb begin
      off_in    = off_ff;
      len_in    = len_ff;
      halted_in = halted_ff;
      if (!halted_ff) begin
         if (off_ff == OFF_LEN) begin
            if (req_data_byte < LEN_MIN) begin
               halted_in = 1'b1;
            end else begin
               len_in = req_data_byte;
               off_in = 8'd1;
            end
         end else if (finish) begin
            off_in = 8'd0;
            if (int_in_ep) begin
               halted_in = 1'b1;
            end
         end else begin
            off_in = off_next[7:0];
         end
      end
   end

   // Push an event for matches and for the final byte
   always_comb begin
      push                 = accept && (req_last_byte || hid_iface || int_in_ep);
      push_event.last      = req_last_byte;
      push_event.hid_iface = hid_iface;
      push_event.int_in_ep = int_in_ep;
      push_event.byte_two  = b2_in;
      push_event.byte_four = b4_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff    <= '0;
         len_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            off_ff    <= '0;
            len_ff    <= '0;
            halted_ff <= 1'b0;
         end else begin
            off_ff    <= off_in;
            len_ff    <= len_in;
            halted_ff <= halted_in;
         end
      end
   end

   // Captured bytes
   always_ff @(posedge clock) begin
      if (accept && !halted_ff) begin
         type_ff <= type_in;
         b2_ff   <= b2_in;
         b3_ff   <= b3_in;
         b4_ff   <= b4_in;
         b5_ff   <= b5_in;
      end
   end

`include "config_descriptor_endpoint_finder_macros.svh"

   `CDEF_ASSERT_NEXT(a_halt_holds, clock, reset, halted_ff && !(accept && req_last_byte), halted_ff, "parser left halt before final byte")
   `CDEF_ASSERT_IMPL(a_no_match_when_halted, clock, reset, halted_ff, !hid_iface && !int_in_ep, "match raised while halted")

endmodule

// ===== design/cdef_queue.sv =====
// Short event queue between the parser and the result side.
module cdef_queue #(
   parameter int DEPTH = cdef_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cdef_pkg::cdef_event_type push_event,
   output logic                     full,
   output logic                     pop_valid,
   input  logic                     pop,
   output cdef_pkg::cdef_event_type pop_event
);
   import cdef_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cdef_event_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_event = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

`include "config_descriptor_endpoint_finder_macros.svh"

   `CDEF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count over depth")

endmodule

// ===== design/cdef_back.sv =====
// Back end: applies classified events and holds the result register.
module cdef_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ev_valid,
   input  cdef_pkg::cdef_event_type ev,
   output logic                     ev_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_found,
   output logic [7:0]               rsp_interface_number,
   output logic [3:0]               rsp_endpoint_number,
   output logic [4:0]               rsp_max_packet
);
   import cdef_pkg::*;

   logic       seen_ff, seen_in;
   logic [7:0] iface_ff, iface_in;
   logic [3:0] ep_ff, ep_in;
   logic [4:0] pkt_ff, pkt_in;

   logic       rsp_valid_ff;
   logic       rsp_found_ff;
   logic [7:0] rsp_iface_ff;
   logic [3:0] rsp_ep_ff;
   logic [4:0] rsp_pkt_ff;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ev_pop    = ev_valid && (!ev.last || slot_free);

   // Held state with the popped event applied
   always_comb begin
      seen_in  = seen_ff;
      iface_in = iface_ff;
      ep_in    = ep_ff;
      pkt_in   = pkt_ff;
      if (ev.hid_iface) begin
         iface_in = ev.byte_two;
      end
      if (ev.int_in_ep) begin
         seen_in = 1'b1;
         ep_in   = ev.byte_two[3:0];
         pkt_in  = packet_fallback(ev.byte_four);
      end
   end

   // Held state, cleared after the final byte's result
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         iface_ff <= '0;
         ep_ff    <= '0;
         pkt_ff   <= MPS_DEFAULT;
      end else if (ev_pop) begin
         if (ev.last) begin
            seen_ff  <= 1'b0;
            iface_ff <= '0;
            ep_ff    <= '0;
            pkt_ff   <= MPS_DEFAULT;
         end else begin
            seen_ff  <= seen_in;
            iface_ff <= iface_in;
            ep_ff    <= ep_in;
            pkt_ff   <= pkt_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_pop && ev.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop && ev.last) begin
         rsp_found_ff <= seen_in;
         rsp_iface_ff <= iface_in;
         rsp_ep_ff    <= ep_in;
         rsp_pkt_ff   <= pkt_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_interface_number = rsp_iface_ff;
   assign rsp_endpoint_number  = rsp_ep_ff;
   assign rsp_max_packet       = rsp_pkt_ff;

`include "config_descriptor_endpoint_finder_macros.svh"

   `CDEF_ASSERT_NEXT(a_clear_after_last, clock, reset, ev_pop && ev.last, rsp_valid_ff && !seen_ff && (pkt_ff == MPS_DEFAULT), "state not cleared after final byte")
   `CDEF_ASSERT_IMPL(a_packet_range, clock, reset, rsp_valid_ff, (rsp_pkt_ff != 5'd0) && (rsp_pkt_ff <= 5'd16), "max packet out of range")

endmodule

// ===== design/config_descriptor_endpoint_finder.sv =====
// The final byte's event passes through the event queue into the result register, which sets rsp_valid once it is free.
// Throughput: one byte per cycle; req_ready drops only while the event queue is full,
// which, with a queue depth above one, happens only when the result register is stalled by rsp_ready.
// The queue depth (QUEUE_DEPTH) sets how many events may wait.
// Reset is synchronous, active high, and clears parser, queue and held state at once.
// Top level: USB configuration descriptor interrupt IN endpoint finder.
module config_descriptor_endpoint_finder #(
   parameter int QUEUE_DEPTH = cdef_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_interface_number,
   output logic [3:0] rsp_endpoint_number,
   output logic [4:0] rsp_max_packet
);
   import cdef_pkg::*;

   logic           queue_full;
   logic           push;
   cdef_event_type push_event;
   logic           ev_valid;
   logic           ev_pop;
   cdef_event_type ev;

   cdef_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_event    (push_event)
   );

   cdef_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop_valid  (ev_valid),
      .pop        (ev_pop),
      .pop_event  (ev)
   );

   cdef_back u_back (
      .clock                (clock),
      .reset                (reset),
      .ev_valid             (ev_valid),
      .ev                   (ev),
      .ev_pop               (ev_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_found            (rsp_found),
      .rsp_interface_number (rsp_interface_number),
      .rsp_endpoint_number  (rsp_endpoint_number),
      .rsp_max_packet       (rsp_max_packet)
   );

endmodule
